>>> rtl/bblur_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_pkg: shared types and constants of the 3x3 box blur
// Pixel, line store and request types, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package bblur_pkg;

    localparam int PIX_W          = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_IDX_W      = 1;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_HEIGHT_DEF   = 4096;
    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    // Sum of up to nine channel values, and the neighbor count.
    localparam int SUM_W = 12;
    localparam int CNT_W = 4;

    // Division by the neighbor count is a multiply by a scaled reciprocal.
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    // Result queue depth.
    localparam int QDEPTH = 8;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic             cmd;
        logic [PIX_W-1:0] pix_red;
        logic [PIX_W-1:0] pix_green;
        logic [PIX_W-1:0] pix_blue;
    } t_in_req;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic             frame_end;
    } t_out_req;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } t_rgb;

    // One column of the window: index 0 is the oldest row.
    typedef t_rgb [2:0] t_col;
    // Three columns: index 0 is the leftmost.
    typedef t_col [2:0] t_grid;

    // One entry of the line store: the two previous rows at one column.
    typedef struct packed {
        t_rgb older;
        t_rgb newer;
    } t_line;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sum;

endpackage
`default_nettype wire

>>> rtl/bblur_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_if: streaming channels of the 3x3 box blur
// Valid/ready channels for input requests and for result requests.
// ----------------------------------------------------------------------------
interface bblur_in_if;
    import bblur_pkg::*;

    logic    valid;
    logic    ready;
    t_in_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface

interface bblur_out_if;
    import bblur_pkg::*;

    logic     valid;
    logic     ready;
    t_out_req req;

    modport source (output valid, output req, input ready);
    modport sink   (input valid, input req, output ready);
endinterface
`default_nettype wire

>>> rtl/box_blur_3x3_rgb_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core: streaming 3x3 box blur over RGB frames
// Raster-order pixels in, per-channel rounded means of the in-bounds 3x3
// neighborhood out, with flush requests draining the final row.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Handshake      Payload
//   i_in     in   valid/ready    cmd, pix_red, pix_green, pix_blue
//   o_out    out  valid/ready    out_red, out_green, out_blue, frame_end
//   i_cfg    in   write enable   register index, write data
//
// One input request is taken in every cycle while the result queue has room;
// a request's results go through the sum register, then the divide, into the
// queue. The rate is set by the line store, which serves one
// pixel column per cycle. Reset clears the position counters, the queue and
// the pipeline at once; the line store is not cleared and needs no pass.
// A stalled output fills the eight-entry queue, and ready drops as soon as
// the queue and the requests in flight could no longer take two more results.
//
// Each pixel request shifts a new column into the 3x3 window: the two stored
// rows at that column come from the line store, the new pixel fills the bottom.
// The result centered one row up and one column left is then summed. The last
// pixel of a row also gives the result for the rightmost column. After the
// final row has been read in, flush requests walk that row once more, taking
// three columns from the line store through two read ports and a held column.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH  = bblur_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bblur_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bblur_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bblur_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bblur_in_if.sink                             i_in,
    bblur_out_if.source                          o_out
);
    import bblur_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int Q_AW  = $clog2(QDEPTH);
    localparam int OCC_W = Q_AW + 2;
    localparam int PROD_W = SUM_W + RECIP_W;
    localparam int QUOT_W = PROD_W - RECIP_SHIFT;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [COL_W-1:0] last_col_of(input logic [FRAME_WIDTH_W-1:0] v);
        int w;
        w = int'(v);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return COL_W'(w - 1);
    endfunction

    function automatic logic [ROW_W-1:0] last_row_of(input logic [FRAME_HEIGHT_W-1:0] v);
        int h;
        h = int'(v);
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return ROW_W'(h - 1);
    endfunction

    // Sum of the cells selected by the row and column masks.
    function automatic t_sum sum_grid(input t_grid g, input logic [2:0] rm,
                                      input logic [2:0] cm);
        t_sum s;
        s = '0;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                if (rm[i] && cm[j]) begin
                    s.cnt   = s.cnt + CNT_W'(1);
                    s.red   = s.red + SUM_W'(g[j][i].r);
                    s.green = s.green + SUM_W'(g[j][i].g);
                    s.blue  = s.blue + SUM_W'(g[j][i].b);
                end
            end
        end
        return s;
    endfunction

    // Scaled reciprocals, exact for every dividend below 2^15.
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] m;
        case (n)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd6:    m = 17'd10923;
            4'd9:    m = 17'd7282;
            default: m = '0;
        endcase
        return m;
    endfunction

    // Rounded mean with halves going up, clamped to the pixel range.
    function automatic logic [PIX_W-1:0] div_chan(input logic [SUM_W-1:0] s,
                                                  input logic [CNT_W-1:0] n);
        logic [SUM_W-1:0]  x;
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] q;
        x    = s + SUM_W'(n >> 1);
        prod = PROD_W'(x) * PROD_W'(recip(n));
        q    = prod[PROD_W-1:RECIP_SHIFT];
        return (q > QUOT_W'(PIX_MAX)) ? PIX_MAX : q[PIX_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Frame position and configuration
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_col, n_col, cur_col, rd_addr_a, rd_addr_b;
    logic [ROW_W-1:0] r_row, n_row, cur_row;
    logic             r_draining, n_draining;
    logic [COL_W-1:0] r_last_col;
    logic [ROW_W-1:0] r_last_row;

    logic acc_in, is_pix, is_flush;

    assign acc_in   = i_in.valid && i_in.ready;
    assign is_pix   = acc_in && (i_in.req.cmd == CMD_PIXEL);
    // A flush outside the drain phase is taken and has no effect.
    assign is_flush = acc_in && (i_in.req.cmd == CMD_FLUSH) && r_draining;

    // A pixel that arrives while the last row drains starts a new frame.
    assign cur_col = r_draining ? '0 : r_col;
    assign cur_row = r_draining ? '0 : r_row;

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_draining = r_draining;
        if (i_cfg_we) begin
            n_col      = '0;
            n_row      = '0;
            n_draining = 1'b0;
        end else if (is_pix) begin
            n_draining = 1'b0;
            n_row      = cur_row;
            if (cur_col == r_last_col) begin
                n_col = '0;
                if (cur_row == r_last_row) begin
                    n_row      = '0;
                    n_draining = 1'b1;
                end else begin
                    n_row = cur_row + ROW_W'(1);
                end
            end else begin
                n_col = cur_col + COL_W'(1);
            end
        end else if (is_flush) begin
            if (r_col == r_last_col) begin
                n_col      = '0;
                n_row      = '0;
                n_draining = 1'b0;
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_draining <= 1'b0;
            r_last_col <= last_col_of(FRAME_WIDTH_W'(FRAME_WIDTH_RST));
            r_last_row <= last_row_of(FRAME_HEIGHT_W'(FRAME_HEIGHT_RST));
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_draining <= n_draining;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_FRAME_WIDTH: begin
                        r_last_col <= last_col_of(i_cfg_data[FRAME_WIDTH_W-1:0]);
                    end
                    REG_FRAME_HEIGHT: begin
                        r_last_row <= last_row_of(i_cfg_data[FRAME_HEIGHT_W-1:0]);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: port A always holds the column at the current position (the
    // next pixel or flush), port B the column after it, so the data is ready.
    // ------------------------------------------------------------------
    t_line ram_q_a, ram_q_b, ram_wdata, line_a, line_b, r_byp_data;
    logic  r_byp_a, r_byp_b;
    t_rgb  pix;

    assign rd_addr_a = n_col;
    assign rd_addr_b = n_col + COL_W'(1);

    assign pix.r = i_in.req.pix_red;
    assign pix.g = i_in.req.pix_green;
    assign pix.b = i_in.req.pix_blue;

    // A write at the column being read (one- and two-pixel rows) is
    // forwarded, since the RAM returns the old contents.
    assign line_a = r_byp_a ? r_byp_data : ram_q_a;
    assign line_b = r_byp_b ? r_byp_data : ram_q_b;

    assign ram_wdata.older = line_a.newer;
    assign ram_wdata.newer = pix;

    bblur_ram #(
        .WIDTH ($bits(t_line)),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (is_pix),
        .i_waddr   (cur_col),
        .i_wdata   (ram_wdata),
        .i_raddr_a (rd_addr_a),
        .o_rdata_a (ram_q_a),
        .i_raddr_b (rd_addr_b),
        .o_rdata_b (ram_q_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_a <= 1'b0;
            r_byp_b <= 1'b0;
        end else begin
            r_byp_a <= is_pix && (cur_col == rd_addr_a);
            r_byp_b <= is_pix && (cur_col == rd_addr_b);
        end
        r_byp_data <= ram_wdata;
    end

    // ------------------------------------------------------------------
    // Window and neighborhood sums
    // ------------------------------------------------------------------
    t_grid r_win, nw, fg, grid0;
    t_line r_dprev;
    logic [2:0] rm_pix, cm_pix0, cm_pix1, rm_fl, cm_fl, rm0, cm0;
    logic  lane0_v, lane1_v;
    t_sum  sum0, sum1;

    always_comb begin
        nw[0]    = r_win[1];
        nw[1]    = r_win[2];
        nw[2][0] = line_a.older;
        nw[2][1] = line_a.newer;
        nw[2][2] = pix;

        fg[0][0] = r_dprev.older;
        fg[0][1] = r_dprev.newer;
        fg[0][2] = '0;
        fg[1][0] = line_a.older;
        fg[1][1] = line_a.newer;
        fg[1][2] = '0;
        fg[2][0] = line_b.older;
        fg[2][1] = line_b.newer;
        fg[2][2] = '0;

        rm_pix  = {1'b1, 1'b1, (cur_row[ROW_W-1:1] != '0)};
        cm_pix0 = {1'b1, 1'b1, (cur_col[COL_W-1:1] != '0)};
        // Rightmost result of a row: its right neighbor lies outside.
        cm_pix1 = {1'b1, (cur_col != '0), 1'b0};

        rm_fl = {1'b0, 1'b1, (r_last_row != '0)};
        cm_fl = {(r_col != r_last_col), 1'b1, (r_col != '0)};

        grid0 = is_pix ? nw : fg;
        rm0   = is_pix ? rm_pix : rm_fl;
        cm0   = is_pix ? cm_pix0 : cm_fl;

        lane0_v = (is_pix && (cur_row != '0) && (cur_col != '0)) || is_flush;
        lane1_v = is_pix && (cur_row != '0) && (cur_col == r_last_col);

        sum0 = sum_grid(grid0, rm0, cm0);
        sum1 = sum_grid(nw, rm_pix, cm_pix1);
    end

    logic [1:0] r_s1_v;
    t_sum       r_s1_sum0, r_s1_sum1;
    logic       r_s1_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= '0;
        end else begin
            r_s1_v <= {lane1_v, lane0_v};
        end
        if (is_pix) begin
            r_win <= nw;
        end
        if (is_flush) begin
            r_dprev <= line_a;
        end
        r_s1_sum0 <= sum0;
        r_s1_sum1 <= sum1;
        r_s1_fe   <= is_flush && (r_col == r_last_col);
    end

    // ------------------------------------------------------------------
    // Divide and result queue
    // ------------------------------------------------------------------
    t_out_req             r_q [QDEPTH];
    t_out_req             res0, res1;
    logic [Q_AW-1:0]      r_q_wp, r_q_rp, wr_addr1;
    logic [Q_AW:0]        r_q_cnt;
    logic [OCC_W-1:0]     occ;
    logic                 pop;

    assign res0.out_red   = div_chan(r_s1_sum0.red, r_s1_sum0.cnt);
    assign res0.out_green = div_chan(r_s1_sum0.green, r_s1_sum0.cnt);
    assign res0.out_blue  = div_chan(r_s1_sum0.blue, r_s1_sum0.cnt);
    assign res0.frame_end = r_s1_fe;
    assign res1.out_red   = div_chan(r_s1_sum1.red, r_s1_sum1.cnt);
    assign res1.out_green = div_chan(r_s1_sum1.green, r_s1_sum1.cnt);
    assign res1.out_blue  = div_chan(r_s1_sum1.blue, r_s1_sum1.cnt);
    assign res1.frame_end = 1'b0;

    assign wr_addr1 = r_q_wp + Q_AW'(r_s1_v[0]);

    assign o_out.valid = (r_q_cnt != '0);
    assign o_out.req   = r_q[r_q_rp];
    assign pop         = o_out.valid && o_out.ready;

    // Room for two more results beyond those queued and in flight.
    assign occ = OCC_W'(r_q_cnt) + OCC_W'(r_s1_v[0]) + OCC_W'(r_s1_v[1]);
    assign i_in.ready = i_rst_n && (occ <= OCC_W'(QDEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= '0;
            r_q_rp  <= '0;
            r_q_cnt <= '0;
        end else begin
            r_q_wp  <= r_q_wp + Q_AW'(r_s1_v[0]) + Q_AW'(r_s1_v[1]);
            r_q_rp  <= r_q_rp + Q_AW'(pop);
            r_q_cnt <= r_q_cnt + (Q_AW+1)'(r_s1_v[0]) + (Q_AW+1)'(r_s1_v[1])
                     - (Q_AW+1)'(pop);
        end
        if (r_s1_v[0]) begin
            r_q[r_q_wp] <= res0;
        end
        if (r_s1_v[1]) begin
            r_q[wr_addr1] <= res1;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= (Q_AW+1)'(QDEPTH))
        else $error("result queue overflow");

    a_idle_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.req.cmd == CMD_FLUSH) && !r_draining)
        |=> (r_s1_v == 2'b00))
        else $error("flush outside drain produced a result");

    a_drain_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_row == '0))
        else $error("row counter not cleared while draining");

    a_frame_end_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v[0] && r_s1_fe) |-> !r_s1_v[1])
        else $error("frame end paired with a second result");
`endif
endmodule
`default_nettype wire

>>> rtl/bblur_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_ram: generic RAM, one write port and two registered read ports
// Reads return the contents from before a write at the same edge.
// ----------------------------------------------------------------------------
module bblur_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= mem[i_raddr_a];
        r_rdata_b <= mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule
`default_nettype wire
